FILE: rtl/core/lict_pkg.sv
// Package for the local interrupt controller timer.
// Holds register offsets, function codes, field widths and the transaction structs.
// No dependencies; compiled first.
package lict_pkg;

   // Field widths
   localparam int FUNC_W   = 2;
   localparam int OFFSET_W = 10;
   localparam int DATA_W   = 32;
   localparam int VECTOR_W = 8;
   localparam int DIVCODE_W = 4;
   localparam int PRESCALE_W = 7;
   localparam int DIVISOR_W  = PRESCALE_W + 1;

   // Function codes carried by a request transaction
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // Register byte offsets
   localparam logic [OFFSET_W-1:0] REG_LVT_TIMER = 10'h320;
   localparam logic [OFFSET_W-1:0] REG_INITIAL   = 10'h380;
   localparam logic [OFFSET_W-1:0] REG_CURRENT   = 10'h390;
   localparam logic [OFFSET_W-1:0] REG_DIVIDE    = 10'h3E0;

   // Register bit positions
   localparam int LVT_MASK_BIT     = 16;
   localparam int LVT_PERIODIC_BIT = 17;
   localparam logic [DIVCODE_W-1:0] DIV_KEEP_MASK = 4'hB;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [OFFSET_W-1:0] reg_offset;
      logic [DATA_W-1:0]   write_data;
   } lict_cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic                irq_fire;
      logic [VECTOR_W-1:0] irq_vector;
   } lict_rsp_type;

   // Divisor for a divide configuration code: 2^((v+1) mod 8),
   // v = {bit3, bit1, bit0}
   function automatic logic [DIVISOR_W-1:0] divisor_of(input logic [DIVCODE_W-1:0] code);
      logic [2:0] v;
      logic [2:0] sh;
      v  = {code[3], code[1:0]};
      sh = v + 3'd1;
      return DIVISOR_W'(1) << sh;
   endfunction

endpackage

FILE: rtl/core/lict_if.sv
// Handshake interfaces for the local interrupt controller timer.
// Request and response channels with valid/ready; depends on lict_pkg.
interface lict_req_if;
   logic                          valid;
   logic                          ready;
   logic [lict_pkg::FUNC_W-1:0]   func;
   logic [lict_pkg::OFFSET_W-1:0] reg_offset;
   logic [lict_pkg::DATA_W-1:0]   write_data;

   modport source (output valid, output func, output reg_offset, output write_data,
                   input ready);
   modport sink   (input valid, input func, input reg_offset, input write_data,
                   output ready);
endinterface

interface lict_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lict_pkg::DATA_W-1:0]   read_data;
   logic                          irq_fire;
   logic [lict_pkg::VECTOR_W-1:0] irq_vector;

   modport source (output valid, output read_data, output irq_fire, output irq_vector,
                   input ready);
   modport sink   (input valid, input read_data, input irq_fire, input irq_vector,
                   output ready);
endinterface

FILE: rtl/core/lict_regs.sv
// Register file and countdown logic of the timer.
// Updates state on each accepted transaction and forms its result; uses lict_pkg.
module lict_regs (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  lict_pkg::lict_cmd_type cmd,
   output lict_pkg::lict_rsp_type rsp
);
   import lict_pkg::*;

   logic [VECTOR_W-1:0]    lvt_vector_ff, lvt_vector_in;
   logic                   lvt_masked_ff, lvt_masked_in;
   logic                   lvt_periodic_ff, lvt_periodic_in;
   logic [DIVCODE_W-1:0]   divide_code_ff, divide_code_in;
   logic [DATA_W-1:0]      initial_count_ff, initial_count_in;
   logic [DATA_W-1:0]      current_count_ff, current_count_in;
   logic [PRESCALE_W-1:0]  prescale_ff, prescale_in;

   logic [DIVISOR_W-1:0]   divisor;
   logic [DIVISOR_W-1:0]   prescale_next;
   logic [DATA_W-1:0]      count_dec;

   assign divisor       = divisor_of(divide_code_ff);
   assign prescale_next = {1'b0, prescale_ff} + DIVISOR_W'(1);
   assign count_dec     = current_count_ff - DATA_W'(1);

   // Next state and result for one transaction
   always_comb begin
      lvt_vector_in    = lvt_vector_ff;
      lvt_masked_in    = lvt_masked_ff;
      lvt_periodic_in  = lvt_periodic_ff;
      divide_code_in   = divide_code_ff;
      initial_count_in = initial_count_ff;
      current_count_in = current_count_ff;
      prescale_in      = prescale_ff;
      rsp              = '0;

      case (cmd.func)
         FUNC_TICK: begin
            // stopped timer holds everything
            if (current_count_ff != '0) begin
               if (prescale_next >= divisor) begin
                  prescale_in      = '0;
                  current_count_in = count_dec;
                  if (count_dec == '0) begin
                     rsp.irq_fire   = ~lvt_masked_ff;
                     rsp.irq_vector = lvt_masked_ff ? '0 : lvt_vector_ff;
                     if (lvt_periodic_ff) begin
                        current_count_in = initial_count_ff;
                     end
                  end
               end else begin
                  prescale_in = prescale_next[PRESCALE_W-1:0];
               end
            end
         end
         FUNC_WRITE: begin
            case (cmd.reg_offset)
               REG_LVT_TIMER: begin
                  lvt_vector_in   = cmd.write_data[VECTOR_W-1:0];
                  lvt_masked_in   = cmd.write_data[LVT_MASK_BIT];
                  lvt_periodic_in = cmd.write_data[LVT_PERIODIC_BIT];
               end
               REG_INITIAL: begin
                  initial_count_in = cmd.write_data;
                  current_count_in = cmd.write_data;
                  prescale_in      = '0;
               end
               REG_DIVIDE: begin
                  divide_code_in = cmd.write_data[DIVCODE_W-1:0] & DIV_KEEP_MASK;
               end
               default: begin
                  // current count is read-only; unlisted offsets ignored
               end
            endcase
         end
         FUNC_READ: begin
            case (cmd.reg_offset)
               REG_LVT_TIMER: begin
                  rsp.read_data[VECTOR_W-1:0]      = lvt_vector_ff;
                  rsp.read_data[LVT_MASK_BIT]      = lvt_masked_ff;
                  rsp.read_data[LVT_PERIODIC_BIT]  = lvt_periodic_ff;
               end
               REG_INITIAL: rsp.read_data = initial_count_ff;
               REG_CURRENT: rsp.read_data = current_count_ff;
               REG_DIVIDE:  rsp.read_data = DATA_W'(divide_code_ff);
               default:     rsp.read_data = '0;
            endcase
         end
         default: begin
            // unused function code: no effect, zero result
         end
      endcase
   end

   // State registers, updated only on an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         lvt_vector_ff    <= '0;
         lvt_masked_ff    <= 1'b1;
         lvt_periodic_ff  <= 1'b0;
         divide_code_ff   <= '0;
         initial_count_ff <= '0;
         current_count_ff <= '0;
         prescale_ff      <= '0;
      end else if (cmd_valid) begin
         lvt_vector_ff    <= lvt_vector_in;
         lvt_masked_ff    <= lvt_masked_in;
         lvt_periodic_ff  <= lvt_periodic_in;
         divide_code_ff   <= divide_code_in;
         initial_count_ff <= initial_count_in;
         current_count_ff <= current_count_in;
         prescale_ff      <= prescale_in;
      end
   end

endmodule

FILE: rtl/core/local_interrupt_controller_timer.sv
// Top level of the local interrupt controller timer (x86 local APIC timer style).
// Depends on lict_pkg, lict_if.sv and lict_regs.
//
//   channel | dir | handshake    | payload
//   --------+-----+--------------+-------------------------------------
//   req_    | in  | valid/ready  | func, reg_offset, write_data
//   rsp_    | out | valid/ready  | read_data, irq_fire, irq_vector
//
// One transaction per cycle while the output register is empty or draining; the
// result is registered at acceptance. The single step is a prescaler compare and
// a 32-bit decrement, between the state registers and the output register.
// Request ready is high whenever the output register is empty or being drained.
// Synchronous reset empties the output register and restores register defaults.
module local_interrupt_controller_timer (
   input logic        clock,
   input logic        reset,
   lict_req_if.sink   req_port,
   lict_rsp_if.source rsp_port
);
   import lict_pkg::*;

   lict_cmd_type cmd;
   lict_rsp_type result;
   lict_rsp_type rsp_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         req_accept;

   // Request side
   assign req_port.ready = ~rsp_valid_ff | rsp_port.ready;
   assign req_accept     = req_port.valid & req_port.ready;
   assign cmd.func       = req_port.func;
   assign cmd.reg_offset = req_port.reg_offset;
   assign cmd.write_data = req_port.write_data;

   lict_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_accept),
      .cmd       (cmd),
      .rsp       (result)
   );

   // Output register
   assign rsp_valid_in = req_accept | (rsp_valid_ff & ~rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.read_data  = rsp_data_ff.read_data;
   assign rsp_port.irq_fire   = rsp_data_ff.irq_fire;
   assign rsp_port.irq_vector = rsp_data_ff.irq_vector;

   // Checks
   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("output register not empty after reset");

   a_fire_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      req_accept && (cmd.func != FUNC_TICK) |=> !rsp_data_ff.irq_fire)
      else $error("interrupt raised by a non-tick transaction");

   a_read_data_only_on_read: assert property (@(posedge clock) disable iff (reset)
      req_accept && (cmd.func != FUNC_READ) |=> (rsp_data_ff.read_data == '0))
      else $error("read data nonzero for a non-read transaction");

   a_vector_needs_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.irq_fire |-> (rsp_data_ff.irq_vector == '0))
      else $error("vector shown without interrupt");

endmodule
